@@ hdl/bwa_pkg.sv @@
package bwa_pkg;

   // Field widths fixed by the register map and the stream words.
   localparam int SAMPLE_W     = 12;
   localparam int WINDOW_W     = 8;
   localparam int LIMIT_W      = 13;
   localparam int PERCENT_W    = 7;
   localparam int PCT_NUM_W    = 20;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 24;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;

   localparam int WINDOW_MAX_DEFAULT = 128;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [PERCENT_W-1:0] PERCENT_FULL = 7'd100;

   localparam logic [WINDOW_W-1:0] WINDOW_LENGTH_RESET = 8'd128;
   localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET_RESET = 12'd0;
   localparam logic [LIMIT_W-1:0]  UPPER_LIMIT_RESET   = 13'd4200;
   localparam logic [LIMIT_W-1:0]  LOWER_LIMIT_RESET   = 13'd3000;

   typedef enum logic [1:0] {
      REG_WINDOW_LENGTH = 2'd0,
      REG_SAMPLE_OFFSET = 2'd1,
      REG_UPPER_LIMIT   = 2'd2,
      REG_LOWER_LIMIT   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [WINDOW_W-1:0] window_length;
      logic [SAMPLE_W-1:0] sample_offset;
      logic [LIMIT_W-1:0]  upper_limit;
      logic [LIMIT_W-1:0]  lower_limit;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_AVG_WAIT,
      ST_PCT_PREP,
      ST_PCT_START,
      ST_PCT_WAIT,
      ST_EMIT
   } state_type;

endpackage

@@ hdl/bwa_ram.sv @@
module bwa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/bwa_front.sv @@
module bwa_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [bwa_pkg::SAMPLE_W-1:0]  in_sample,
   input  logic [bwa_pkg::SAMPLE_W-1:0]  sample_offset,
   output logic                          q_valid,
   output logic [bwa_pkg::SAMPLE_W-1:0]  q_sample,
   input  logic                          q_ready
);

   import bwa_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [SAMPLE_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SAMPLE_W-1:0] offset_sample;
   logic                push, pop;

   // Offset removal saturates at zero.
   assign offset_sample = (in_sample > sample_offset) ? (in_sample - sample_offset) : '0;

   assign in_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign q_valid  = (count_ff != '0);
   assign q_sample = entry_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= offset_sample;
      end
   end

endmodule

@@ hdl/bwa_div.sv @@
module bwa_div #(
   parameter int DW = 20,
   parameter int VW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [VW-1:0]    dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [VW:0]      partial;
   logic [VW:0]      trial;

   // One quotient bit per cycle, restoring form.
   assign partial = {rem_ff, dvd_ff[DW-1]};
   assign trial   = partial - {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[VW]) begin
            rem_in = trial[VW-1:0];
            dvd_in = {dvd_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = partial[VW-1:0];
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

@@ hdl/bwa_back.sv @@
module bwa_back #(
   parameter int WINDOW_MAX = bwa_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bwa_pkg::cfg_type              cfg,
   input  logic                          restart,
   input  logic                          q_valid,
   input  logic [bwa_pkg::SAMPLE_W-1:0]  q_sample,
   output logic                          q_ready,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [bwa_pkg::LIMIT_W-1:0]   out_battery_mv,
   output logic [bwa_pkg::PERCENT_W-1:0] out_charge_percent
);

   import bwa_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_MAX);
   localparam int DIV_DW = (SUM_W > PCT_NUM_W) ? SUM_W : PCT_NUM_W;
   localparam int DIV_VW = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int WL_X   = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;

   state_type            state_ff, state_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 full_ff, full_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [LIMIT_W-1:0]   mv_ff, mv_in;
   logic [PCT_NUM_W-1:0] num_ff, num_in;
   logic [LIMIT_W-1:0]   den_ff, den_in;
   logic [PERCENT_W-1:0] pct_ff, pct_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]   rsp_mv_ff, rsp_mv_in;
   logic [PERCENT_W-1:0] rsp_pct_ff, rsp_pct_in;

   logic [WL_X-1:0]      wl_x;
   logic [CNT_W-1:0]     window_n;
   logic [CNT_W-1:0]     next_cnt;
   logic                 wrap;
   logic                 ram_we;
   logic [SAMPLE_W-1:0]  ram_rdata;
   logic                 div_start;
   logic [DIV_DW-1:0]    div_dividend;
   logic [DIV_VW-1:0]    div_divisor;
   logic                 div_done;
   logic [DIV_DW-1:0]    div_quotient;

   // A window of zero counts as one; one above the ring depth is clamped.
   assign wl_x = WL_X'(cfg.window_length);
   always_comb begin
      if (wl_x == '0) begin
         window_n = CNT_W'(1);
      end else if (wl_x > WL_X'(WINDOW_MAX)) begin
         window_n = CNT_W'(WINDOW_MAX);
      end else begin
         window_n = CNT_W'(wl_x);
      end
   end

   assign next_cnt = CNT_W'(slot_ff) + 1'b1;
   assign wrap     = (next_cnt >= window_n);

   bwa_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(WINDOW_MAX)
   ) u_ring (
      .clock(clock),
      .we   (ram_we),
      .waddr(slot_ff),
      .wdata(sample_ff),
      .raddr(slot_in),
      .rdata(ram_rdata)
   );

   bwa_div #(
      .DW(DIV_DW),
      .VW(DIV_VW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      full_in      = full_ff;
      sum_in       = sum_ff;
      mv_in        = mv_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_mv_in    = rsp_mv_ff;
      rsp_pct_in   = rsp_pct_ff;
      q_ready      = 1'b0;
      ram_we       = 1'b0;
      div_start    = 1'b0;
      div_dividend = DIV_DW'(sum_in);
      div_divisor  = DIV_VW'(window_n);

      case (state_ff)
         ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               sample_in = q_sample;
               slot_in   = (CNT_W'(idx_ff) >= window_n) ? '0 : idx_ff;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // The slot's old sample leaves the sum only once the ring is full.
            ram_we    = 1'b1;
            div_start = 1'b1;
            if (!full_ff) begin
               sum_in      = sum_ff + SUM_W'(sample_ff);
               div_divisor = DIV_VW'(next_cnt);
            end else begin
               sum_in      = sum_ff - SUM_W'(ram_rdata) + SUM_W'(sample_ff);
               div_divisor = DIV_VW'(window_n);
            end
            div_dividend = DIV_DW'(sum_in);
            idx_in       = wrap ? '0 : next_cnt[IDX_W-1:0];
            full_in      = full_ff || wrap;
            state_in     = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_done) begin
               mv_in    = {div_quotient[SAMPLE_W-1:0], 1'b0};
               state_in = ST_PCT_PREP;
            end
         end
         ST_PCT_PREP: begin
            if (mv_ff <= cfg.lower_limit) begin
               pct_in   = '0;
               state_in = ST_EMIT;
            end else if (cfg.upper_limit <= cfg.lower_limit) begin
               pct_in   = PERCENT_FULL;
               state_in = ST_EMIT;
            end else begin
               num_in   = PCT_NUM_W'(mv_ff - cfg.lower_limit) * PCT_NUM_W'(PERCENT_FULL);
               den_in   = cfg.upper_limit - cfg.lower_limit;
               state_in = ST_PCT_START;
            end
         end
         ST_PCT_START: begin
            div_start    = 1'b1;
            div_dividend = DIV_DW'(num_ff);
            div_divisor  = DIV_VW'(den_ff);
            state_in     = ST_PCT_WAIT;
         end
         ST_PCT_WAIT: begin
            if (div_done) begin
               pct_in   = (div_quotient > DIV_DW'(PERCENT_FULL)) ?
                          PERCENT_FULL : div_quotient[PERCENT_W-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || out_ready) begin
               rsp_valid_in = 1'b1;
               rsp_mv_in    = mv_ff;
               rsp_pct_in   = pct_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (restart) begin
         sum_in  = '0;
         idx_in  = '0;
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         full_ff      <= full_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      slot_ff    <= slot_in;
      mv_ff      <= mv_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      pct_ff     <= pct_in;
      rsp_mv_ff  <= rsp_mv_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   assign out_valid          = rsp_valid_ff;
   assign out_battery_mv     = rsp_mv_ff;
   assign out_charge_percent = rsp_pct_ff;

endmodule

@@ hdl/battery_window_average_percent_unit.sv @@
// Battery monitor: moving average of converter samples and a charge estimate.
// Words of calibrated converter millivolts arrive on the req_ stream. Each has
// the configured offset removed (saturating at zero) and is placed in a short
// two-word queue; a sequencer behind it updates the sample ring and running sum,
// divides by the fill count or the window length, doubles the result into
// battery millivolts and divides again for the percentage between the limits.
// Both divisions share one restoring divider that produces one quotient bit a
// cycle, and the sequencer takes a new word only once the last one's result is
// stored in the output register. When the voltage is at or below the lower
// limit, or the upper limit is not above the lower one, the second division is
// skipped. One word is processed at a time; the queue keeps accepting while the
// sequencer works.
// Each result word is held in an output register on the rsp_ stream until it
// is taken; a stalled receiver holds the sequencer in its last step and, once
// the queue is full, backs up req_tready. The user must write registers on the
// csr_ port only while the block is idle; the block itself does not enforce it.
// A write to window_length restarts the average. Reset loads the register
// defaults and empties the queue and ring.
module battery_window_average_percent_unit #(
   parameter int WINDOW_MAX = bwa_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // req_tdata: [11:0] sample_mv, [15:12] zero
   input  logic [bwa_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // rsp_tdata: [12:0] battery_mv, [19:13] charge_percent, [23:20] zero
   output logic [bwa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bwa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [bwa_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [bwa_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   import bwa_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   logic                  csr_write;
   logic                  restart;
   reg_index_type         reg_index;
   logic                  q_valid;
   logic                  q_ready;
   logic [SAMPLE_W-1:0]   q_sample;
   logic [LIMIT_W-1:0]    out_mv;
   logic [PERCENT_W-1:0]  out_pct;

   // Register i lives at byte address 4*i; the low address bits are ignored.
   assign reg_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in  = cfg_ff;
      restart = 1'b0;
      if (csr_write) begin
         case (reg_index)
            REG_WINDOW_LENGTH: begin
               cfg_in.window_length = csr_pwdata[WINDOW_W-1:0];
               restart              = 1'b1;
            end
            REG_SAMPLE_OFFSET: cfg_in.sample_offset = csr_pwdata[SAMPLE_W-1:0];
            REG_UPPER_LIMIT:   cfg_in.upper_limit   = csr_pwdata[LIMIT_W-1:0];
            REG_LOWER_LIMIT:   cfg_in.lower_limit   = csr_pwdata[LIMIT_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_WINDOW_LENGTH: csr_prdata = CSR_DATA_W'(cfg_ff.window_length);
         REG_SAMPLE_OFFSET: csr_prdata = CSR_DATA_W'(cfg_ff.sample_offset);
         REG_UPPER_LIMIT:   csr_prdata = CSR_DATA_W'(cfg_ff.upper_limit);
         REG_LOWER_LIMIT:   csr_prdata = CSR_DATA_W'(cfg_ff.lower_limit);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length <= WINDOW_LENGTH_RESET;
         cfg_ff.sample_offset <= SAMPLE_OFFSET_RESET;
         cfg_ff.upper_limit   <= UPPER_LIMIT_RESET;
         cfg_ff.lower_limit   <= LOWER_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end strips the offset and queues the word.
   bwa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_sample    (req_tdata[SAMPLE_W-1:0]),
      .sample_offset(cfg_ff.sample_offset),
      .q_valid      (q_valid),
      .q_sample     (q_sample),
      .q_ready      (q_ready)
   );

   // The back end owns the ring, the running sum and the shared divider.
   bwa_back #(
      .WINDOW_MAX(WINDOW_MAX)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .restart           (restart),
      .q_valid           (q_valid),
      .q_sample          (q_sample),
      .q_ready           (q_ready),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .out_battery_mv    (out_mv),
      .out_charge_percent(out_pct)
   );

   assign rsp_tdata = RSP_DATA_W'({out_pct, out_mv});

endmodule

@@ test/tb_battery_window_average_percent_unit.sv @@
`timescale 1ns / 100ps

module tb_battery_window_average_percent_unit;
   import bwa_pkg::*;

   // The ring depth that the block is built with; the predictor clamps the window to it.
   localparam int WINDOW_MAX = WINDOW_MAX_DEFAULT;
   // Cycles without any handshake on either stream or the register port before giving up.
   localparam int STALL_LIMIT = 4000;
   // Cycles allowed after the last result so that a late extra word would still be caught.
   localparam int DRAIN_CYCLES = 64;

   // One result word as the block packs it: battery millivolts low, percentage above.
   typedef struct packed {
      logic [PERCENT_W-1:0] charge_percent;
      logic [LIMIT_W-1:0]   battery_mv;
   } reading_type;

   // The scoreboard mirrors the block: it keeps the register values, the sample ring and
   // the running sum, and turns every accepted sample into the reading that must follow.
   class battery_reading_scoreboard;
      logic [WINDOW_W-1:0] window_length;
      logic [SAMPLE_W-1:0] sample_offset;
      logic [LIMIT_W-1:0]  upper_limit;
      logic [LIMIT_W-1:0]  lower_limit;
      logic [SAMPLE_W-1:0] sample_ring [WINDOW_MAX];
      int unsigned         window_sum;
      int unsigned         write_slot;
      bit                  ring_full;
      reading_type         pending_readings [$];
      int unsigned         mismatches;

      function new();
         window_length = WINDOW_LENGTH_RESET;
         sample_offset = SAMPLE_OFFSET_RESET;
         upper_limit   = UPPER_LIMIT_RESET;
         lower_limit   = LOWER_LIMIT_RESET;
         mismatches    = 0;
         restart_average();
      endfunction

      function void restart_average();
         window_sum = 0;
         write_slot = 0;
         ring_full  = 1'b0;
      endfunction

      function void apply_register(reg_index_type index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_WINDOW_LENGTH: begin
               window_length = value[WINDOW_W-1:0];
               restart_average();
            end
            REG_SAMPLE_OFFSET: sample_offset = value[SAMPLE_W-1:0];
            REG_UPPER_LIMIT:   upper_limit   = value[LIMIT_W-1:0];
            REG_LOWER_LIMIT:   lower_limit   = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] raw_mv);
         int unsigned window;
         int unsigned trimmed;
         int unsigned slot;
         int unsigned average;
         int unsigned percent;
         reading_type reading;
         window = (window_length == 0) ? 1 : window_length;
         if (window > WINDOW_MAX)
            window = WINDOW_MAX;
         trimmed = (raw_mv > sample_offset) ? raw_mv - sample_offset : 0;
         slot = (write_slot >= window) ? 0 : write_slot;
         if (!ring_full) begin
            // Still filling: divide by the number of samples held so far.
            sample_ring[slot] = SAMPLE_W'(trimmed);
            window_sum += trimmed;
            slot++;
            average = window_sum / slot;
            if (slot >= window) begin
               slot = 0;
               ring_full = 1'b1;
            end
         end else begin
            window_sum = window_sum - sample_ring[slot] + trimmed;
            sample_ring[slot] = SAMPLE_W'(trimmed);
            slot++;
            if (slot >= window)
               slot = 0;
            average = window_sum / window;
         end
         write_slot = slot;
         reading.battery_mv = LIMIT_W'(average * 2);
         if (reading.battery_mv <= lower_limit)
            percent = 0;
         else if (upper_limit <= lower_limit)
            percent = PERCENT_FULL;
         else begin
            percent = (100 * (reading.battery_mv - lower_limit)) / (upper_limit - lower_limit);
            if (percent > PERCENT_FULL)
               percent = PERCENT_FULL;
         end
         reading.charge_percent = PERCENT_W'(percent);
         pending_readings.push_back(reading);
      endfunction

      function void check_reading(logic [RSP_DATA_W-1:0] word);
         reading_type got;
         reading_type want;
         got = word[LIMIT_W+PERCENT_W-1:0];
         if (pending_readings.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: unexpected reading mv=%0d pct=%0d", $realtime,
                        got.battery_mv, got.charge_percent);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (got.battery_mv !== want.battery_mv ||
                got.charge_percent !== want.charge_percent) begin
               if (mismatches < 10)
                  $display("%0t: reading mismatch: expected mv=%0d pct=%0d, got mv=%0d pct=%0d",
                           $realtime, want.battery_mv, want.charge_percent,
                           got.battery_mv, got.charge_percent);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // req_tdata: [11:0] sample_mv, [15:12] zero
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // rsp_tdata: [12:0] battery_mv, [19:13] charge_percent, [23:20] zero
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   battery_reading_scoreboard readings = new();
   int                     samples_sent = 0;
   int                     burst_left = 1;
   int                     idle_cycles = 0;

   battery_window_average_percent_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver stalls on a pattern of its own, switching between taking every word,
   // taking at random, taking rarely and a fixed rhythm.
   always @(negedge clock) begin : receiver_pattern
      static int stall_mode = 0;
      static int mode_left = 0;
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(64, 256);
      end else
         mode_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ((mode_left % 7) < 3);
      endcase
   end

   // Results are checked at the rising edge at which they are taken. Any handshake on
   // either stream or the register port counts as progress for the watchdog.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         readings.check_reading(rsp_tdata);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // A register write has a setup phase and an access phase; the register is written at
   // the edge at which the access phase meets pready.
   task automatic write_register(reg_index_type index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      readings.apply_register(index, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Offers one sample word and waits for it to be taken. The sender works in bursts;
   // at the end of a burst it drops tvalid for a random gap.
   task automatic send_sample(logic [SAMPLE_W-1:0] sample_mv);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-SAMPLE_W){1'b0}}, sample_mv};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      readings.note_sample(sample_mv);
      samples_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 12);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 30))
            @(negedge clock);
      end
   endtask

   // Registers may only change while the block is idle, so every reading has to be back
   // and the sequencer given time to fall quiet before the next write.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (readings.pending_readings.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES)
         @(posedge clock);
   endtask

   initial begin
      int phase_words;
      int span_low;
      int span_high;
      int target_mv;
      int sample;
      int lower;
      int upper;

      repeat (4)
         @(negedge clock);
      reset <= 1'b0;

      // Register defaults: a window of 128 still filling, limits of 3000 and 4200 mV.
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd1500);
      send_sample(12'd2100);
      settle();

      // A window of one makes the battery voltage exactly twice the trimmed sample, so the
      // limits can be hit precisely: at the lower limit, just above it, at the upper limit
      // and above it, plus both extremes of the sample.
      write_register(REG_WINDOW_LENGTH, 32'd1);
      write_register(REG_SAMPLE_OFFSET, 32'd0);
      write_register(REG_UPPER_LIMIT, 32'd4200);
      write_register(REG_LOWER_LIMIT, 32'd3000);
      send_sample(12'd1500);
      send_sample(12'd1501);
      send_sample(12'd2100);
      send_sample(12'd2101);
      send_sample(12'd4095);
      send_sample(12'd0);
      settle();

      // A window of zero behaves as one; the largest offset trims every sample to zero.
      write_register(REG_WINDOW_LENGTH, 32'd0);
      write_register(REG_SAMPLE_OFFSET, 32'd4095);
      send_sample(12'd4095);
      send_sample(12'd100);
      settle();

      // Equal limits: zero percent at the limit and full charge just above it.
      write_register(REG_SAMPLE_OFFSET, 32'd100);
      write_register(REG_UPPER_LIMIT, 32'd2000);
      write_register(REG_LOWER_LIMIT, 32'd2000);
      send_sample(12'd1100);
      send_sample(12'd1101);
      settle();

      // Upper limit below the lower one.
      write_register(REG_UPPER_LIMIT, 32'd1000);
      write_register(REG_LOWER_LIMIT, 32'd3000);
      send_sample(12'd1600);
      send_sample(12'd1601);
      settle();

      // Widest limits and a window above the ring depth, which is clamped to it.
      write_register(REG_WINDOW_LENGTH, 32'd255);
      write_register(REG_SAMPLE_OFFSET, 32'd0);
      write_register(REG_UPPER_LIMIT, 32'd8190);
      write_register(REG_LOWER_LIMIT, 32'd0);
      send_sample(12'd4095);
      send_sample(12'd0);
      send_sample(12'd4095);
      settle();

      // Random phases. Each rewrites a random subset of the registers; when the window is
      // left alone the average carries on across the phase boundary.
      while (samples_sent < 1250) begin
         if ($urandom_range(0, 1) == 0)
            case ($urandom_range(0, 7))
               0: write_register(REG_WINDOW_LENGTH, 32'd1);
               1: write_register(REG_WINDOW_LENGTH, 32'd2);
               2: write_register(REG_WINDOW_LENGTH, 32'd128);
               3: write_register(REG_WINDOW_LENGTH, 32'd0);
               4: write_register(REG_WINDOW_LENGTH, $urandom_range(129, 255));
               default: write_register(REG_WINDOW_LENGTH, $urandom_range(3, 48));
            endcase
         if ($urandom_range(0, 1) == 0)
            case ($urandom_range(0, 2))
               0: write_register(REG_SAMPLE_OFFSET, 32'd0);
               1: write_register(REG_SAMPLE_OFFSET, $urandom_range(0, 4095));
               default: write_register(REG_SAMPLE_OFFSET, $urandom_range(0, 600));
            endcase
         case ($urandom_range(0, 5))
            0, 1: begin
               lower = $urandom_range(2400, 3400);
               upper = lower + $urandom_range(100, 1500);
            end
            2: begin
               lower = $urandom_range(0, 8190);
               upper = $urandom_range(0, 8190);
            end
            3: begin
               lower = $urandom_range(0, 8190);
               upper = lower;
            end
            4: begin
               lower = 0;
               upper = 8190;
            end
            default: begin
               upper = $urandom_range(0, 4000);
               lower = upper + $urandom_range(1, 3000);
            end
         endcase
         if ($urandom_range(0, 1) == 0)
            write_register(REG_UPPER_LIMIT, upper);
         if ($urandom_range(0, 1) == 0)
            write_register(REG_LOWER_LIMIT, lower);

         // Most samples are aimed so that the battery voltage lands around the limits in
         // force, which is where the percentage changes; the rest cover the whole range.
         span_low  = (readings.lower_limit < readings.upper_limit) ? readings.lower_limit
                                                                   : readings.upper_limit;
         span_high = (readings.lower_limit < readings.upper_limit) ? readings.upper_limit
                                                                   : readings.lower_limit;
         span_low  = (span_low > 300) ? span_low - 300 : 0;
         span_high = (span_high + 300 > 8190) ? 8190 : span_high + 300;
         phase_words = $urandom_range(40, 160);
         repeat (phase_words) begin
            if ($urandom_range(0, 2) == 0)
               sample = $urandom_range(0, 4095);
            else begin
               target_mv = $urandom_range(span_low, span_high);
               sample = target_mv / 2 + readings.sample_offset + $urandom_range(0, 40) - 20;
               if (sample < 0)
                  sample = 0;
               if (sample > 4095)
                  sample = 4095;
            end
            send_sample(SAMPLE_W'(sample));
         end
         settle();
      end

      if (readings.mismatches == 0 && readings.pending_readings.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/bwa_pkg.sv
hdl/bwa_ram.sv
hdl/bwa_front.sv
hdl/bwa_div.sv
hdl/bwa_back.sv
hdl/battery_window_average_percent_unit.sv
test/tb_battery_window_average_percent_unit.sv
